// ----- src/sac_pkg.sv -----
// Shared constants, register map and types of the stereo audio compressor.
package sac_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WET       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY       = 3'd5;

    // Fixed-point formats
    localparam int LEVEL_W = 15;
    localparam int COEF_W  = 16;
    localparam int GAIN_W  = 17;
    localparam int QUOT_W  = 16;
    localparam int MIX_W   = 35;
    localparam int MIX_LO_W = 18;

    localparam logic [GAIN_W-1:0]  GAIN_ONE   = 17'd65536;
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 17'd98304;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 15'd32767;

    localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 15'd6554;
    localparam logic [COEF_W-1:0]  SLOPE_RST     = 16'd58982;
    localparam logic [COEF_W-1:0]  ATTACK_RST    = 16'd64797;
    localparam logic [COEF_W-1:0]  RELEASE_RST   = 16'd65530;
    localparam logic [COEF_W-1:0]  WET_RST       = 16'd16384;
    localparam logic [COEF_W-1:0]  DRY_RST       = 16'd0;

    // Command to the shared root/divide unit
    typedef struct packed {
        logic                start;
        logic                is_div;
        logic [QUOT_W-1:0]   dividend;
        logic [LEVEL_W-1:0]  divisor;
    } rd_cmd_t;

endpackage

// ----- src/sac_in_if.sv -----
// Input channel carrying one stereo sample pair per transaction.
interface sac_in_if #(parameter int SAMPLE_BITS = sac_pkg::SAMPLE_BITS_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

// ----- src/sac_out_if.sv -----
// Output channel carrying one processed stereo pair per transaction.
interface sac_out_if #(parameter int SAMPLE_BITS = sac_pkg::SAMPLE_BITS_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          clipped;

    modport source (output valid, output left_out, output right_out, output clipped,
                    input ready);
    modport sink (input valid, input left_out, input right_out, input clipped,
                  output ready);
endinterface

// ----- src/stereo_audio_compressor_top.sv -----
// An accepted pair passes the squares, the level's square root and, above the threshold,
// a quotient; then the gain smoothing and the wet/dry mix. Pairs are taken one at a time;
// the bit-a-cycle root/divide unit (square root, then quotient) and the single shared
// multiplier set the rate.
// A finished result waits in the output register while the next pair is taken in.
// Reset (rst_n, asynchronous) loads the register defaults and a smoothed gain of 1.5.
module stereo_audio_compressor_top #(
    parameter int SAMPLE_BITS = sac_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    sac_in_if.sink                            sample_ch,
    sac_out_if.source                         result_ch,
    input  logic                              cfg_we,
    input  logic [sac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sac_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int MW   = (SB > MIX_LO_W) ? SB : MIX_LO_W;
    localparam int PW   = 2 * MW + 2;
    localparam int AW   = PW + MIX_LO_W + 1;
    localparam int QW   = (SB > QUOT_W) ? SB : QUOT_W;
    localparam int LW   = (SB > 16) ? SB : 17;
    localparam int SH_R = (SB >= 16) ? SB - 16 : 0;
    localparam int SH_L = (SB < 16) ? 16 - SB : 0;

    localparam logic signed [AW-1:0] S_MAX = (AW'(1) <<< (SB - 1)) - AW'(1);
    localparam logic signed [AW-1:0] S_MIN = -S_MAX - AW'(1);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_SQL  = 5'd1;
    localparam logic [4:0] ST_SQR  = 5'd2;
    localparam logic [4:0] ST_SQS  = 5'd3;
    localparam logic [4:0] ST_RT0  = 5'd4;
    localparam logic [4:0] ST_RTW  = 5'd5;
    localparam logic [4:0] ST_LVL  = 5'd6;
    localparam logic [4:0] ST_KEPT = 5'd7;
    localparam logic [4:0] ST_DVW  = 5'd8;
    localparam logic [4:0] ST_G1   = 5'd9;
    localparam logic [4:0] ST_G2   = 5'd10;
    localparam logic [4:0] ST_G3   = 5'd11;
    localparam logic [4:0] ST_W1   = 5'd12;
    localparam logic [4:0] ST_W2   = 5'd13;
    localparam logic [4:0] ST_M1   = 5'd14;
    localparam logic [4:0] ST_M2   = 5'd15;
    localparam logic [4:0] ST_M3   = 5'd16;
    localparam logic [4:0] ST_M4   = 5'd17;
    localparam logic [4:0] ST_M5   = 5'd18;
    localparam logic [4:0] ST_OUT  = 5'd19;

    logic [4:0]              state_reg, state_next;

    logic [LEVEL_W-1:0]      thr_reg, thr_next;
    logic [COEF_W-1:0]       slope_reg, slope_next;
    logic [COEF_W-1:0]       att_reg, att_next;
    logic [COEF_W-1:0]       rel_reg, rel_next;
    logic [COEF_W-1:0]       wet_reg, wet_next;
    logic [COEF_W-1:0]       dry_reg, dry_next;
    logic [GAIN_W-1:0]       gain_reg, gain_next;
    logic                    out_valid_reg, out_valid_next;

    logic signed [SB-1:0]    l_reg, l_next;
    logic signed [SB-1:0]    r_reg, r_next;
    logic signed [AW-1:0]    acc_reg, acc_next;
    logic [LEVEL_W-1:0]      level_reg, level_next;
    logic [GAIN_W-1:0]       target_reg, target_next;
    logic [COEF_W-1:0]       coef_reg, coef_next;
    logic [MIX_W-1:0]        mix_reg, mix_next;
    logic signed [SB-1:0]    left_reg, left_next;
    logic signed [SB-1:0]    right_reg, right_next;
    logic                    clip_reg, clip_next;
    logic signed [SB-1:0]    out_left_reg, out_left_next;
    logic signed [SB-1:0]    out_right_reg, out_right_next;
    logic                    out_clip_reg, out_clip_next;

    logic signed [MW:0]      mul_a;
    logic [MW-1:0]           mul_b;
    logic signed [PW-1:0]    prod;
    logic signed [AW-1:0]    prod_ext;
    logic signed [AW-1:0]    sum_lo;
    logic signed [AW-1:0]    sum_hi;
    logic signed [AW-1:0]    mix_y;
    logic signed [SB-1:0]    sat_val;
    logic                    sat_clip;

    logic [SB-1:0]           abs_l;
    logic [SB-1:0]           abs_r;
    logic [LW-1:0]           lvl_wide;
    logic [LEVEL_W-1:0]      level_sat;
    logic [COEF_W-1:0]       coef_sel;
    logic [GAIN_W-1:0]       one_minus;
    logic [MIX_LO_W-1:0]     wet3;
    logic [QUOT_W-1:0]       kept;

    rd_cmd_t                 rd_cmd;
    logic                    rd_done;
    logic [QW-1:0]           rd_result;

    sac_mul #(.MW(MW)) u_sac_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    sac_rootdiv #(.SB(SB)) u_sac_rootdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (rd_cmd),
        .radicand (acc_reg[2*SB:1]),
        .done     (rd_done),
        .result   (rd_result)
    );

    // Datapath helpers
    always_comb
    begin
        abs_l     = l_reg[SB-1] ? SB'(-l_reg) : SB'(l_reg);
        abs_r     = r_reg[SB-1] ? SB'(-r_reg) : SB'(r_reg);
        lvl_wide  = (LW'(rd_result[SB-1:0]) >> SH_R) << SH_L;
        level_sat = (lvl_wide > LW'(LEVEL_MAX)) ? LEVEL_MAX : lvl_wide[LEVEL_W-1:0];
        coef_sel  = (target_reg < gain_reg) ? att_reg : rel_reg;
        one_minus = GAIN_ONE - {1'b0, coef_reg};
        wet3      = MIX_LO_W'({wet_reg, 1'b0}) + MIX_LO_W'(wet_reg);
        kept      = {1'b0, thr_reg} + prod[31:16];
        prod_ext  = AW'(prod);
        sum_lo    = acc_reg + prod_ext;
        sum_hi    = acc_reg + (prod_ext <<< MIX_LO_W);
        // Arithmetic shift rounds toward minus infinity.
        mix_y     = sum_hi >>> 31;
        sat_clip  = 1'b1;
        if (mix_y > S_MAX)
        begin
            sat_val = S_MAX[SB-1:0];
        end
        else if (mix_y < S_MIN)
        begin
            sat_val = S_MIN[SB-1:0];
        end
        else
        begin
            sat_val  = mix_y[SB-1:0];
            sat_clip = 1'b0;
        end
    end

    // Operand selection for the shared multiplier; its product is registered and shows in the next cycle.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQL:
            begin
                mul_a = $signed((MW + 1)'(abs_l));
                mul_b = MW'(abs_l);
            end
            ST_SQR:
            begin
                mul_a = $signed((MW + 1)'(abs_r));
                mul_b = MW'(abs_r);
            end
            ST_LVL:
            begin
                mul_a = $signed((MW + 1)'(level_reg - thr_reg));
                mul_b = MW'(slope_reg);
            end
            ST_G1:
            begin
                mul_a = $signed((MW + 1)'(gain_reg));
                mul_b = MW'(coef_sel);
            end
            ST_G2:
            begin
                mul_a = $signed((MW + 1)'(target_reg));
                mul_b = MW'(one_minus);
            end
            ST_W1:
            begin
                mul_a = $signed((MW + 1)'(gain_reg));
                mul_b = MW'(wet3);
            end
            ST_M1:
            begin
                mul_a = (MW + 1)'(l_reg);
                mul_b = MW'(mix_reg[MIX_LO_W-1:0]);
            end
            ST_M2:
            begin
                mul_a = (MW + 1)'(l_reg);
                mul_b = MW'(mix_reg[MIX_W-1:MIX_LO_W]);
            end
            ST_M3:
            begin
                mul_a = (MW + 1)'(r_reg);
                mul_b = MW'(mix_reg[MIX_LO_W-1:0]);
            end
            ST_M4:
            begin
                mul_a = (MW + 1)'(r_reg);
                mul_b = MW'(mix_reg[MIX_W-1:MIX_LO_W]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        thr_next       = thr_reg;
        slope_next     = slope_reg;
        att_next       = att_reg;
        rel_next       = rel_reg;
        wet_next       = wet_reg;
        dry_next       = dry_reg;
        gain_next      = gain_reg;
        out_valid_next = out_valid_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        level_next     = level_reg;
        target_next    = target_reg;
        coef_next      = coef_reg;
        mix_next       = mix_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        clip_next      = clip_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_clip_next  = out_clip_reg;
        rd_cmd         = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_next   = cfg_data[LEVEL_W-1:0];
                CFG_SLOPE:     slope_next = cfg_data;
                CFG_ATTACK:    att_next   = cfg_data;
                CFG_RELEASE:   rel_next   = cfg_data;
                CFG_WET:       wet_next   = cfg_data;
                CFG_DRY:       dry_next   = cfg_data;
                default:       thr_next   = thr_reg;
            endcase
        end

        if (out_valid_reg && result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    l_next     = sample_ch.left_sample;
                    r_next     = sample_ch.right_sample;
                    state_next = ST_SQL;
                end
            end
            ST_SQL:
            begin
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                acc_next   = prod_ext;
                state_next = ST_SQS;
            end
            ST_SQS:
            begin
                acc_next   = sum_lo;
                state_next = ST_RT0;
            end
            ST_RT0:
            begin
                rd_cmd.start  = 1'b1;
                rd_cmd.is_div = 1'b0;
                state_next    = ST_RTW;
            end
            ST_RTW:
            begin
                if (rd_done)
                begin
                    level_next = level_sat;
                    state_next = ST_LVL;
                end
            end
            ST_LVL:
            begin
                if (level_reg > thr_reg)
                begin
                    state_next = ST_KEPT;
                end
                else
                begin
                    target_next = GAIN_ONE;
                    state_next  = ST_G1;
                end
            end
            ST_KEPT:
            begin
                rd_cmd.start    = 1'b1;
                rd_cmd.is_div   = 1'b1;
                rd_cmd.dividend = kept;
                rd_cmd.divisor  = level_reg;
                state_next      = ST_DVW;
            end
            ST_DVW:
            begin
                if (rd_done)
                begin
                    target_next = {1'b0, rd_result[QUOT_W-1:0]};
                    state_next  = ST_G1;
                end
            end
            ST_G1:
            begin
                coef_next  = coef_sel;
                state_next = ST_G2;
            end
            ST_G2:
            begin
                acc_next   = prod_ext;
                state_next = ST_G3;
            end
            ST_G3:
            begin
                gain_next  = sum_lo[GAIN_W+15:16];
                state_next = ST_W1;
            end
            ST_W1:
            begin
                state_next = ST_W2;
            end
            ST_W2:
            begin
                mix_next   = prod[MIX_W-1:0] + MIX_W'({dry_reg, 17'd0});
                state_next = ST_M1;
            end
            ST_M1:
            begin
                state_next = ST_M2;
            end
            ST_M2:
            begin
                acc_next   = prod_ext;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                left_next  = sat_val;
                clip_next  = sat_clip;
                state_next = ST_M4;
            end
            ST_M4:
            begin
                acc_next   = prod_ext;
                state_next = ST_M5;
            end
            ST_M5:
            begin
                right_next = sat_val;
                clip_next  = clip_reg | sat_clip;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold here until the output register is free.
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_left_next  = left_reg;
                    out_right_next = right_reg;
                    out_clip_next  = clip_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= THRESHOLD_RST;
            slope_reg     <= SLOPE_RST;
            att_reg       <= ATTACK_RST;
            rel_reg       <= RELEASE_RST;
            wet_reg       <= WET_RST;
            dry_reg       <= DRY_RST;
            gain_reg      <= GAIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            thr_reg       <= thr_next;
            slope_reg     <= slope_next;
            att_reg       <= att_next;
            rel_reg       <= rel_next;
            wet_reg       <= wet_next;
            dry_reg       <= dry_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg         <= l_next;
        r_reg         <= r_next;
        acc_reg       <= acc_next;
        level_reg     <= level_next;
        target_reg    <= target_next;
        coef_reg      <= coef_next;
        mix_reg       <= mix_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        clip_reg      <= clip_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_clip_reg  <= out_clip_next;
    end

    assign sample_ch.ready    = (state_reg == ST_IDLE);
    assign result_ch.valid    = out_valid_reg;
    assign result_ch.left_out  = out_left_reg;
    assign result_ch.right_out = out_right_reg;
    assign result_ch.clipped   = out_clip_reg;
endmodule

// ----- src/sac_mul.sv -----
// Shared signed-by-unsigned multiplier with a registered product.
module sac_mul #(
    parameter int MW = 18
) (
    input  logic                clk,
    input  logic signed [MW:0]  a,
    input  logic [MW-1:0]       b,
    output logic signed [2*MW+1:0] p
);
    logic signed [2*MW+1:0] p_reg;
    logic signed [2*MW+1:0] p_next;

    assign p_next = a * $signed({1'b0, b});

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;
endmodule

// ----- src/sac_rootdiv.sv -----
// Shared digit-recurrence unit: integer square root or 16-bit quotient, one bit a cycle.
module sac_rootdiv #(
    parameter int SB = sac_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sac_pkg::rd_cmd_t       cmd,
    input  logic [2*SB-1:0]        radicand,
    output logic                   done,
    output logic [((SB > sac_pkg::QUOT_W) ? SB : sac_pkg::QUOT_W)-1:0] result
);
    import sac_pkg::*;

    localparam int QW = (SB > QUOT_W) ? SB : QUOT_W;
    localparam int RW = (SB + 2 > QUOT_W + 1) ? SB + 2 : QUOT_W + 1;
    localparam int SW = RW + 2;
    localparam int CW = $clog2(QW + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               div_reg, div_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [2*SB-1:0]    rad_reg, rad_next;
    logic [RW-1:0]      rem_reg, rem_next;
    logic [QW-1:0]      root_reg, root_next;
    logic [LEVEL_W-1:0] dvs_reg, dvs_next;

    logic [SW-1:0]      shifted;
    logic [SW-1:0]      trial;
    logic [SW-1:0]      diff;
    logic               fits;

    // One recurrence step. For the root the trial value is 4*root+1 against the
    // remainder with the next two radicand bits; for the quotient it is the divisor.
    always_comb
    begin
        if (div_reg)
        begin
            shifted = SW'({rem_reg, 1'b0});
            trial   = SW'(dvs_reg);
        end
        else
        begin
            shifted = {rem_reg, rad_reg[2*SB-1 -: 2]};
            trial   = SW'({root_reg, 2'b01});
        end
        fits = (shifted >= trial);
        diff = shifted - trial;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        dvs_next  = dvs_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            div_next  = cmd.is_div;
            cnt_next  = cmd.is_div ? CW'(QUOT_W) : CW'(SB);
            rad_next  = radicand;
            rem_next  = cmd.is_div ? RW'(cmd.dividend) : '0;
            root_next = '0;
            dvs_next  = cmd.divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? RW'(diff) : RW'(shifted);
            root_next = {root_reg[QW-2:0], fits};
            rad_next  = rad_reg << 2;
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dvs_reg  <= dvs_next;
    end

    assign done   = done_reg;
    assign result = root_reg;
endmodule

// ----- src/sac_checker.sv -----
// Port-level checks of the compressor top level, attached by bind.
module sac_checker #(
    parameter int SB = sac_pkg::SAMPLE_BITS_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic signed [SB-1:0] left_out,
    input logic signed [SB-1:0] right_out,
    input logic                 clipped
);
    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB - 1){1'b0}}};

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out)
            && $stable(clipped))
        else $error("output transaction changed while stalled");

    // The block works on one pair at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted again right after a transaction");

    // A clipped result has at least one channel at full scale.
    a_clip_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> (left_out == S_MAX) || (left_out == S_MIN)
            || (right_out == S_MAX) || (right_out == S_MIN))
        else $error("clipped set without a saturated channel");

    // Results are not immediate: out_valid never rises straight after an accepted input.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared one cycle after input");
endmodule

bind stereo_audio_compressor_top sac_checker #(.SB(SAMPLE_BITS)) u_sac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .left_out  (result_ch.left_out),
    .right_out (result_ch.right_out),
    .clipped   (result_ch.clipped)
);
